FILE: sv/bldc_pkg.sv
package bldc_pkg;

   // link control characters
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_HT  = 8'h09;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_SYN = 8'h16;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // bytes after stx at which the id bytes and crc digits are all in
   localparam logic [2:0] ID_BYTES   = 3'd2;
   localparam logic [2:0] MIN_BLOCK  = 3'd6;

   typedef enum logic [2:0] {
      PH_WAIT_SYN = 3'd0,
      PH_COUNT_HI = 3'd1,
      PH_COUNT_LO = 3'd2,
      PH_HUNT_STX = 3'd3,
      PH_IN_BLOCK = 3'd4,
      PH_WAIT_END = 3'd5
   } phase_type;

   // control from the framing logic to the crc unit
   typedef struct packed {
      logic       clear;
      logic       step;
      logic [7:0] data;
   } crc_ctrl_type;

   // hex digit to 0..15, bit 4 set for anything that is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

FILE: sv/bldc_crc_unit.sv
module bldc_crc_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  bldc_pkg::crc_ctrl_type ctrl,
   output logic [15:0]           crc_value
);
   import bldc_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [7:0]  x0;
   logic [7:0]  x;

   // ccitt polynomial 0x1021, one byte per beat, msb first
   always_comb begin
      x0 = crc_ff[15:8] ^ ctrl.data;
      x  = x0 ^ {4'b0, x0[7:4]};
      crc_in = crc_ff;
      if (ctrl.clear) begin
         crc_in = CRC_INIT;
      end else if (ctrl.step) begin
         crc_in = {crc_ff[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
                  ^ {8'h00, x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

FILE: sv/block_link_deframer_crc16.sv
// Receive side of an ASCII block link. Each req beat carries one received
// byte; each accepted byte yields exactly one rsp beat, shown in the cycle
// after, and a new byte is taken every cycle while the rsp register
// is empty or being drained. An opening SYN is answered with SYN, two hex
// digits give the block count (zero is NAKed, otherwise ACKed). Each block is
// STX, two id bytes, data, four hex CRC digits and ETX. Data bytes leave
// through a four-byte delay line with NUL and HT turned into space, and feed
// a CRC-16 (0x1021, init and xorout FFFF). At ETX the block is ACKed or NAKed;
// a block of fewer than six bytes is always NAKed, and the CRC digits are
// compared only while csr_wr_data last written was 1. A NAKed block keeps the
// count and the next STX starts its resend. A SYN after the last block closes
// the message with ACK. The CRC step and the state update share a clock edge.
module block_link_deframer_crc16 (
   input  logic        clock,
   input  logic        reset,
   // config: crc_check_enable
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // rx byte stream, tdata: rx_byte[7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // result stream, tdata from bit 0: reply_valid, reply_byte[8], payload_valid,
   // payload_byte[8], block_done, block_ok, message_done, 3 zero pad bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata
);
   import bldc_pkg::*;

   // config register
   logic        crc_en_ff;

   // framing state
   phase_type   phase_ff, phase_in;
   logic [3:0]  count_hi_ff, count_hi_in;
   logic [7:0]  blocks_left_ff, blocks_left_in;
   logic [2:0]  bss_ff, bss_in;          // bytes after stx, saturating at six
   logic [7:0]  window_ff [4];           // [0] newest, [3] oldest
   logic [7:0]  window_in [4];

   // result register
   logic        rsp_valid_ff;
   logic        reply_valid_in,  reply_valid_ff;
   logic [7:0]  reply_byte_in,   reply_byte_ff;
   logic        payload_valid_in, payload_valid_ff;
   logic [7:0]  payload_byte_in, payload_byte_ff;
   logic        block_done_in,   block_done_ff;
   logic        block_ok_in,     block_ok_ff;
   logic        message_done_in, message_done_ff;

   logic         accept;
   logic [7:0]   rx;
   logic [4:0]   hex_rx;
   logic [4:0]   hd [4];
   logic         crc_digits_ok;
   logic         block_ok;
   logic         is_data;              // byte goes into the delay line
   logic         is_out;               // oldest window byte leaves as payload
   logic [7:0]   blocks_dec;
   logic [15:0]  crc_value;
   crc_ctrl_type crc_ctrl;

   assign rx         = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign hex_rx     = hex_value(rx);
   assign blocks_dec = blocks_left_ff - 8'd1;

   // etx verdict: long enough, and with checking on, four valid digits equal
   // to the inverted running crc
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hd[i] = hex_value(window_ff[i]);
      end
      crc_digits_ok = !(hd[3][4] || hd[2][4] || hd[1][4] || hd[0][4]) &&
                      ({hd[3][3:0], hd[2][3:0], hd[1][3:0], hd[0][3:0]} == ~crc_value);
      block_ok = (bss_ff == MIN_BLOCK) && (!crc_en_ff || crc_digits_ok);
   end

   // data path through the block: id bytes are counted, then bytes shift in
   assign is_data = (phase_ff == PH_IN_BLOCK) && (rx != CH_ETX) && (bss_ff >= ID_BYTES);
   assign is_out  = is_data && (bss_ff == MIN_BLOCK);

   // next state
   always_comb begin
      phase_in       = phase_ff;
      count_hi_in    = count_hi_ff;
      blocks_left_in = blocks_left_ff;
      bss_in         = bss_ff;
      for (int i = 0; i < 4; i++) begin
         window_in[i] = window_ff[i];
      end
      case (phase_ff)
         PH_COUNT_HI: begin
            count_hi_in = hex_rx[4] ? 4'h0 : hex_rx[3:0];
            phase_in    = PH_COUNT_LO;
         end
         PH_COUNT_LO: begin
            if ({count_hi_ff, (hex_rx[4] ? 4'h0 : hex_rx[3:0])} == 8'h00) begin
               phase_in = PH_WAIT_SYN;
            end else begin
               blocks_left_in = {count_hi_ff, (hex_rx[4] ? 4'h0 : hex_rx[3:0])};
               phase_in       = PH_HUNT_STX;
            end
         end
         PH_HUNT_STX: begin
            if (rx == CH_STX) begin
               bss_in = 3'd0;
               for (int i = 0; i < 4; i++) begin
                  window_in[i] = 8'h00;
               end
               phase_in = PH_IN_BLOCK;
            end
         end
         PH_IN_BLOCK: begin
            if (rx == CH_ETX) begin
               if (block_ok) begin
                  blocks_left_in = blocks_dec;
                  phase_in       = (blocks_dec == 8'h00) ? PH_WAIT_END : PH_HUNT_STX;
               end else begin
                  phase_in = PH_HUNT_STX;
               end
            end else begin
               if (bss_ff != MIN_BLOCK) begin
                  bss_in = bss_ff + 3'd1;
               end
               if (is_data) begin
                  window_in[3] = window_ff[2];
                  window_in[2] = window_ff[1];
                  window_in[1] = window_ff[0];
                  window_in[0] = rx;
               end
            end
         end
         PH_WAIT_END: begin
            if (rx == CH_SYN) begin
               phase_in = PH_WAIT_SYN;
            end
         end
         default: begin
            phase_in = (rx == CH_SYN) ? PH_COUNT_HI : PH_WAIT_SYN;
         end
      endcase
   end

   // result fields
   always_comb begin
      reply_valid_in   = 1'b0;
      reply_byte_in    = 8'h00;
      payload_valid_in = is_out;
      payload_byte_in  = 8'h00;
      block_done_in    = 1'b0;
      block_ok_in      = 1'b0;
      message_done_in  = 1'b0;
      if (is_out) begin
         payload_byte_in = (window_ff[3] == 8'h00 || window_ff[3] == CH_HT) ?
                           CH_SP : window_ff[3];
      end
      case (phase_ff)
         PH_COUNT_HI: begin
         end
         PH_COUNT_LO: begin
            reply_valid_in = 1'b1;
            reply_byte_in  = ({count_hi_ff, (hex_rx[4] ? 4'h0 : hex_rx[3:0])} == 8'h00) ?
                             CH_NAK : CH_ACK;
         end
         PH_HUNT_STX: begin
         end
         PH_IN_BLOCK: begin
            if (rx == CH_ETX) begin
               reply_valid_in = 1'b1;
               block_done_in  = 1'b1;
               block_ok_in    = block_ok;
               reply_byte_in  = block_ok ? CH_ACK : CH_NAK;
            end
         end
         PH_WAIT_END: begin
            if (rx == CH_SYN) begin
               reply_valid_in  = 1'b1;
               reply_byte_in   = CH_ACK;
               message_done_in = 1'b1;
            end
         end
         default: begin
            if (rx == CH_SYN) begin
               reply_valid_in = 1'b1;
               reply_byte_in  = CH_SYN;
            end
         end
      endcase
   end

   // crc runs over the byte leaving the delay line, restarts at stx
   always_comb begin
      crc_ctrl.clear = accept && (phase_ff == PH_HUNT_STX) && (rx == CH_STX);
      crc_ctrl.step  = accept && is_out;
      crc_ctrl.data  = window_ff[3];
   end

   bldc_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .crc_value (crc_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_en_ff      <= 1'b0;
         phase_ff       <= PH_WAIT_SYN;
         count_hi_ff    <= 4'h0;
         blocks_left_ff <= 8'h00;
         bss_ff         <= 3'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            crc_en_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff       <= phase_in;
            count_hi_ff    <= count_hi_in;
            blocks_left_ff <= blocks_left_in;
            bss_ff         <= bss_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: delay line and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 4; i++) begin
            window_ff[i] <= window_in[i];
         end
         reply_valid_ff   <= reply_valid_in;
         reply_byte_ff    <= reply_byte_in;
         payload_valid_ff <= payload_valid_in;
         payload_byte_ff  <= payload_byte_in;
         block_done_ff    <= block_done_in;
         block_ok_ff      <= block_ok_in;
         message_done_ff  <= message_done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, message_done_ff, block_ok_ff, block_done_ff,
                        payload_byte_ff, payload_valid_ff, reply_byte_ff, reply_valid_ff};

   // a byte of data never leaves in the same beat as the block verdict
   a_no_payload_at_etx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(payload_valid_ff && block_done_ff))
      else $error("payload and block end in one beat");

   // every verdict and message end carries a reply
   a_verdict_has_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (block_done_ff || message_done_ff) |-> reply_valid_ff)
      else $error("block or message end without reply");

   // an accepted block is always answered with ack
   a_ok_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && block_ok_ff |-> block_done_ff && reply_byte_ff == CH_ACK)
      else $error("accepted block not acked");

   // the byte counter never passes its saturation point
   a_bss_sat: assert property (@(posedge clock) disable iff (reset)
      bss_ff <= MIN_BLOCK)
      else $error("byte counter beyond saturation");

   // the message end waits on a block count that has run out
   a_wait_end_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT_END |-> blocks_left_ff == 8'h00)
      else $error("closing syn awaited with blocks left");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bldc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
   localparam int SETTLE_CYCLES  = 6;     // quiet cycles once nothing is outstanding
   localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
   localparam int ITEM_TARGET    = 725;

   // one result beat, laid out as rsp_tdata from bit 0 upwards
   typedef struct packed {
      logic [2:0] pad;
      logic       message_done;
      logic       block_ok;
      logic       block_done;
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic [7:0] reply_byte;
      logic       reply_valid;
   } link_result_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_SHORT,
      FRAME_BAD_CRC,
      FRAME_NONHEX_CRC
   } frame_fault_type;

   // link receiver predictor plus the queue of replies still owed by the block
   class link_scoreboard;
      bit              check_en;
      phase_type       phase;
      logic [3:0]      count_hi;
      logic [7:0]      blocks_left;
      logic [2:0]      since_stx;
      logic [7:0]      window [4];
      logic [15:0]     crc;
      link_result_type expected [$];
      int errors, results, payload_bytes, blocks_ok, blocks_bad, messages;

      function new();
         check_en    = 1'b0;
         phase       = PH_WAIT_SYN;
         count_hi    = '0;
         blocks_left = '0;
         since_stx   = '0;
         foreach (window[i]) window[i] = '0;
         crc         = CRC_INIT;
      endfunction

      static function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
         logic [15:0] r;
         r = c ^ {b, 8'h00};
         repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
         return r;
      endfunction

      // 0..15 for a hex digit of either case, 16 otherwise
      static function int digit_value(input logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - 'h30;
         if (c >= "A" && c <= "F") return int'(c) - 'h37;
         if (c >= "a" && c <= "f") return int'(c) - 'h57;
         return 16;
      endfunction

      function void note_byte(input logic [7:0] b);
         link_result_type r;
         int              v, d3, d2, d1, d0;
         logic [7:0]      n, oldest;
         bit              ok;
         r = '0;
         case (phase)
            PH_COUNT_HI: begin
               v = digit_value(b);
               count_hi = (v > 15) ? 4'h0 : v[3:0];
               phase = PH_COUNT_LO;
            end
            PH_COUNT_LO: begin
               v = digit_value(b);
               n = {count_hi, (v > 15) ? 4'h0 : v[3:0]};
               r.reply_valid = 1'b1;
               if (n == 8'h00) begin
                  r.reply_byte = CH_NAK;
                  phase = PH_WAIT_SYN;
               end else begin
                  r.reply_byte = CH_ACK;
                  blocks_left = n;
                  phase = PH_HUNT_STX;
               end
            end
            PH_HUNT_STX: begin
               if (b == CH_STX) begin
                  since_stx = '0;
                  crc = CRC_INIT;
                  foreach (window[i]) window[i] = '0;
                  phase = PH_IN_BLOCK;
               end
            end
            PH_IN_BLOCK: begin
               if (b == CH_ETX) begin
                  ok = (since_stx >= MIN_BLOCK);
                  if (ok && check_en) begin
                     d3 = digit_value(window[3]);
                     d2 = digit_value(window[2]);
                     d1 = digit_value(window[1]);
                     d0 = digit_value(window[0]);
                     if (d3 > 15 || d2 > 15 || d1 > 15 || d0 > 15) ok = 1'b0;
                     else ok = ({d3[3:0], d2[3:0], d1[3:0], d0[3:0]} == ~crc);
                  end
                  r.reply_valid = 1'b1;
                  r.block_done  = 1'b1;
                  if (ok) begin
                     r.reply_byte = CH_ACK;
                     r.block_ok   = 1'b1;
                     blocks_left--;
                     phase = (blocks_left == 8'h00) ? PH_WAIT_END : PH_HUNT_STX;
                  end else begin
                     r.reply_byte = CH_NAK;
                     phase = PH_HUNT_STX;
                  end
               end else if (since_stx < ID_BYTES) begin
                  since_stx++;
               end else begin
                  if (since_stx >= MIN_BLOCK) begin
                     oldest = window[3];
                     crc = crc_next(crc, oldest);
                     r.payload_valid = 1'b1;
                     r.payload_byte  = (oldest == 8'h00 || oldest == CH_HT) ? CH_SP : oldest;
                  end else begin
                     since_stx++;
                  end
                  window[3] = window[2];
                  window[2] = window[1];
                  window[1] = window[0];
                  window[0] = b;
               end
            end
            PH_WAIT_END: begin
               if (b == CH_SYN) begin
                  r.reply_valid  = 1'b1;
                  r.reply_byte   = CH_ACK;
                  r.message_done = 1'b1;
                  phase = PH_WAIT_SYN;
               end
            end
            default: begin
               if (b == CH_SYN) begin
                  r.reply_valid = 1'b1;
                  r.reply_byte  = CH_SYN;
                  phase = PH_COUNT_HI;
               end else begin
                  phase = PH_WAIT_SYN;
               end
            end
         endcase
         expected.push_back(r);
      endfunction

      task report_mismatch(input string what, input int got_v, input int want_v);
         errors++;
         if (errors <= 30)
            $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results, what, got_v, want_v);
      endtask

      task check_result(input link_result_type got);
         link_result_type want;
         if (expected.size() == 0) begin
            report_mismatch("result with nothing outstanding", int'(got), 0);
            return;
         end
         want = expected.pop_front();
         results++;
         if (got.reply_valid !== want.reply_valid)
            report_mismatch("reply_valid", got.reply_valid, want.reply_valid);
         if (got.reply_byte !== want.reply_byte)
            report_mismatch("reply_byte", got.reply_byte, want.reply_byte);
         if (got.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
         if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
         if (got.block_done !== want.block_done)
            report_mismatch("block_done", got.block_done, want.block_done);
         if (got.block_ok !== want.block_ok)
            report_mismatch("block_ok", got.block_ok, want.block_ok);
         if (got.message_done !== want.message_done)
            report_mismatch("message_done", got.message_done, want.message_done);
         if (got.pad !== want.pad)
            report_mismatch("pad bits", got.pad, want.pad);
         if (want.payload_valid) payload_bytes++;
         if (want.block_done && want.block_ok) blocks_ok++;
         if (want.block_done && !want.block_ok) blocks_bad++;
         if (want.message_done) messages++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // rx_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // reply_valid, reply_byte, payload_valid, payload_byte,
                              // block_done, block_ok, message_done, 3 pad bits

   // sb checks the block, shadow runs ahead at stimulus time to steer framing
   link_scoreboard sb     = new();
   link_scoreboard shadow = new();

   logic [7:0] frame_body [$];  // data bytes of the next frame to send
   int         items_sent;
   int         burst_left;
   int         quiet_cycles;
   bit         hold_request;

   block_link_deframer_crc16 i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // monitor: beats taken at the rising edge, replies checked before the new byte is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                     quiet_cycles, sb.expected.size());
            $display("** block_link_deframer_crc16: FAILED **");
            $finish;
         end
      end
   end

   // receiver: changing stall patterns, plus a long hold-off on request
   initial begin
      int mode, span;
      rsp_tready = 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_tready = 1'b0;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = (i % 4) != 0;
               default: rsp_tready = ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + nib;
      return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   function automatic logic [7:0] rand_other(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom); while (b == avoid);
      return b;
   endfunction

   // anything but a hex digit, and never etx so the block is not cut short
   function automatic logic [7:0] rand_nonhex();
      logic [7:0] b;
      do b = 8'($urandom);
      while (link_scoreboard::digit_value(b) < 16 || b == CH_ETX);
      return b;
   endfunction

   // block content byte: leans on the bytes that get special treatment
   function automatic logic [7:0] rand_body_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return CH_HT;
         2: return CH_STX;
         3: return 8'hFF;
         4: return CH_SYN;
         default: return rand_other(CH_ETX);
      endcase
   endfunction

   // offer one byte in bursts with random gaps, wait for the handshake
   task automatic push_byte(input logic [7:0] b);
      int gap;
      shadow.note_byte(b);
      shadow.expected.delete();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // random bytes, but never a count digit that would ask for dozens of blocks
   task automatic push_noise(input int n);
      logic [7:0] b;
      int         v;
      repeat (n) begin
         b = 8'($urandom);
         v = link_scoreboard::digit_value(b);
         if (shadow.phase == PH_COUNT_HI && v >= 2 && v <= 15) b = "1";
         push_byte(b);
      end
   endtask

   // stop sending, wait for every reply, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_crc_check(input bit enable);
      settle();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = enable;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.check_en     = enable;
      shadow.check_en = enable;
   endtask

   // stx, two id bytes, frame_body, four crc digits, etx
   task automatic send_frame(input frame_fault_type fault);
      logic [15:0] fcs;
      logic [7:0]  digit [4];
      int          k;
      fcs = CRC_INIT;
      foreach (frame_body[i]) fcs = link_scoreboard::crc_next(fcs, frame_body[i]);
      fcs = ~fcs;
      for (k = 0; k < 4; k++) digit[k] = hex_char(fcs[15 - 4 * k -: 4], 1'($urandom));
      k = $urandom_range(0, 3);
      if (fault == FRAME_BAD_CRC)
         digit[k] = hex_char(fcs[15 - 4 * k -: 4] ^ 4'($urandom_range(1, 15)), 1'b1);
      else if (fault == FRAME_NONHEX_CRC)
         digit[k] = rand_nonhex();
      push_byte(CH_STX);
      if (fault == FRAME_SHORT) begin
         repeat ($urandom_range(0, 5)) push_byte(rand_body_byte());
      end else begin
         repeat (2) push_byte(rand_body_byte());
         foreach (frame_body[i]) push_byte(frame_body[i]);
         foreach (digit[i]) push_byte(digit[i]);
      end
      push_byte(CH_ETX);
   endtask

   task automatic send_random_frame(input int bad_pct);
      int              len;
      frame_fault_type fault;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      frame_body.delete();
      repeat (len) frame_body.push_back(rand_body_byte());
      fault = FRAME_GOOD;
      if ($urandom_range(0, 99) < bad_pct) fault = frame_fault_type'($urandom_range(1, 3));
      send_frame(fault);
   endtask

   // whole message: syn, count, blocks with resends, closing syn
   task automatic send_message(input int bad_pct);
      logic [7:0] n, hi, lo;
      bit         up;
      case ($urandom_range(0, 24))
         0: n = 8'h00;
         1: n = 8'h10 + 8'($urandom_range(0, 2));
         default: n = 8'($urandom_range(1, 4));
      endcase
      up = 1'($urandom);
      // a non-hex count digit reads as zero
      hi = (n[7:4] == 4'h0 && $urandom_range(0, 3) == 0) ? rand_nonhex() : hex_char(n[7:4], up);
      lo = (n[3:0] == 4'h0 && $urandom_range(0, 3) == 0) ? rand_nonhex() : hex_char(n[3:0], up);
      repeat ($urandom_range(0, 2)) push_byte(rand_other(CH_SYN));
      push_byte(CH_SYN);
      push_byte(hi);
      push_byte(lo);
      while (shadow.phase == PH_HUNT_STX) begin
         repeat ($urandom_range(0, 1)) push_byte(rand_other(CH_STX));
         send_random_frame(bad_pct);
      end
      if (shadow.phase == PH_WAIT_END) begin
         repeat ($urandom_range(0, 2)) push_byte(rand_other(CH_SYN));
         push_byte(CH_SYN);
      end
   endtask

   // walk the link back to waiting for an opening syn from wherever it is
   task automatic return_to_idle();
      while (shadow.phase != PH_WAIT_SYN) begin
         case (shadow.phase)
            PH_COUNT_HI, PH_COUNT_LO: push_byte("0");
            PH_IN_BLOCK:              push_byte(CH_ETX);
            PH_HUNT_STX:              send_random_frame(0);
            default:                  push_byte(CH_SYN);
         endcase
      end
   endtask

   task automatic random_traffic(input int target);
      int kind;
      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_message(20);
         end else if (kind < 85) begin
            // noise dropped into whatever phase the link is in
            push_noise($urandom_range(1, 8));
         end else begin
            // message broken off part-way through a block
            push_byte(CH_SYN);
            push_byte("0");
            push_byte(hex_char(4'($urandom_range(1, 3)), 1'b1));
            push_byte(CH_STX);
            push_noise($urandom_range(1, 10));
         end
         return_to_idle();
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      items_sent  = 0;
      burst_left  = 0;
      quiet_cycles = 0;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_crc_check(1'b1);

      // directed: stray bytes, zero count, non-hex count digit, special data bytes
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CH_SYN);
      push_byte("0");
      push_byte("0");
      push_byte(CH_SYN);
      push_byte("G");
      push_byte("1");
      push_byte(8'hFF);
      frame_body.delete();
      frame_body.push_back(8'h00);
      frame_body.push_back(CH_HT);
      frame_body.push_back(8'hFF);
      frame_body.push_back(CH_STX);
      send_frame(FRAME_GOOD);
      push_byte("A");
      push_byte(CH_SYN);

      // random traffic with crc checking on, off, then on again
      hold_request = 1'b1;
      random_traffic(260);
      set_crc_check(1'b0);
      random_traffic(500);
      set_crc_check(1'b1);
      hold_request = 1'b1;
      random_traffic(ITEM_TARGET);

      settle();
      $display("%0d bytes in, %0d replies checked, crc checking on, off and on again",
               items_sent, sb.results);
      $display("%0d blocks accepted, %0d rejected, %0d payload bytes, %0d messages closed",
               sb.blocks_ok, sb.blocks_bad, sb.payload_bytes, sb.messages);
      if (sb.errors == 0) begin
         $display("** block_link_deframer_crc16: PASSED **");
      end else begin
         $display("** block_link_deframer_crc16: FAILED **");
      end
      $finish;
   end

endmodule
